// ===== rtl/lad_pkg.sv =====
// Shared constants and types for the linear array deque.
package lad_pkg;

    localparam int DEPTH_DEF = 8;
    localparam int DATA_W    = 32;
    localparam int OP_W      = 3;
    localparam int ST_W      = 2;

    localparam logic [OP_W-1:0] OP_PUSH_REAR  = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_REAR   = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
    localparam logic [OP_W-1:0] OP_DISPLAY    = 3'd4;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
    localparam logic [ST_W-1:0] ST_BLOCKED = 2'd2;
    localparam logic [ST_W-1:0] ST_EMPTY   = 2'd3;

    typedef enum logic [0:0] {
        S_IDLE,
        S_DOUT
    } state_t;

endpackage

// ===== rtl/lad_ram.sv =====
// Generic single-clock RAM, one write and one registered read port.
module lad_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/linear_array_deque.sv =====
// Linear array deque: index control, sequencer and output register around one RAM.
//
//   channel | dir | handshake          | payload
//   s_      | in  | s_tvalid/s_tready  | s_tuser = operation, s_tdata = value
//   m_      | out | m_tvalid/m_tready  | m_tuser = status, m_tdata = data, m_tlast
//
// Push and any failing operation: result loaded at accept.
// Pop: the entry RAM read starts at accept; its registered read data is loaded in S_DOUT.
// Display of n words: one RAM read per word; input is held off meanwhile.
// Reset clears the front and end indices, sequencer and output valid; RAM contents are left as is.
// A stalled m_ side freezes the walk; the RAM read data holds until taken.
module linear_array_deque #(
    parameter int DEPTH = lad_pkg::DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [lad_pkg::DATA_W-1:0]  s_tdata,   // [31:0] value
    input  logic [lad_pkg::OP_W-1:0]    s_tuser,   // [2:0] operation
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [lad_pkg::DATA_W-1:0]  m_tdata,   // [31:0] data
    output logic [lad_pkg::ST_W-1:0]    m_tuser,   // [1:0] status
    output logic                        m_tlast
);

    import lad_pkg::*;

    localparam int IDXW = $clog2(DEPTH + 1);
    localparam int AW   = $clog2(DEPTH);

    state_t            state_reg, state_next;
    logic [IDXW-1:0]   front_reg, front_next;
    logic [IDXW-1:0]   end_reg, end_next;
    logic [IDXW-1:0]   cur_reg, cur_next;
    logic              single_reg, single_next;
    logic              m_valid_reg, m_valid_next;
    logic [DATA_W-1:0] m_data_reg;
    logic [ST_W-1:0]   m_status_reg;
    logic              m_last_reg;

    logic              load;
    logic [DATA_W-1:0] ld_data;
    logic [ST_W-1:0]   ld_status;
    logic              ld_last;

    logic              wr_en, rd_en;
    logic [AW-1:0]     wr_addr, rd_addr;
    logic [DATA_W-1:0] rd_data;

    logic              out_free, empty, fin;

    lad_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_tdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_free = !m_valid_reg || m_tready;
    assign empty    = front_reg >= end_reg;
    // pops carry one word; a display ends at the word just below end
    assign fin      = single_reg || ((cur_reg + IDXW'(1)) == end_reg);

    always_comb
    begin
        state_next  = state_reg;
        front_next  = front_reg;
        end_next    = end_reg;
        cur_next    = cur_reg;
        single_next = single_reg;
        s_tready    = 1'b0;
        load        = 1'b0;
        ld_data     = '0;
        ld_status   = ST_OK;
        ld_last     = 1'b1;
        wr_en       = 1'b0;
        wr_addr     = '0;
        rd_en       = 1'b0;
        rd_addr     = '0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = out_free;
                if (s_tvalid && out_free)
                begin
                    case (s_tuser)
                        OP_PUSH_REAR:
                        begin
                            load = 1'b1;
                            if (end_reg == IDXW'(DEPTH))
                            begin
                                ld_status = ST_FULL;
                            end
                            else
                            begin
                                wr_en    = 1'b1;
                                wr_addr  = end_reg[AW-1:0];
                                end_next = end_reg + IDXW'(1);
                            end
                        end
                        OP_PUSH_FRONT:
                        begin
                            load = 1'b1;
                            if (front_reg == '0)
                            begin
                                ld_status = ST_BLOCKED;
                            end
                            else
                            begin
                                front_next = front_reg - IDXW'(1);
                                wr_en      = 1'b1;
                                wr_addr    = front_next[AW-1:0];
                            end
                        end
                        OP_POP_REAR:
                        begin
                            if (empty)
                            begin
                                load      = 1'b1;
                                ld_status = ST_EMPTY;
                            end
                            else
                            begin
                                end_next    = end_reg - IDXW'(1);
                                rd_en       = 1'b1;
                                rd_addr     = end_next[AW-1:0];
                                single_next = 1'b1;
                                state_next  = S_DOUT;
                            end
                        end
                        OP_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                load      = 1'b1;
                                ld_status = ST_EMPTY;
                            end
                            else
                            begin
                                rd_en       = 1'b1;
                                rd_addr     = front_reg[AW-1:0];
                                front_next  = front_reg + IDXW'(1);
                                single_next = 1'b1;
                                state_next  = S_DOUT;
                            end
                        end
                        OP_DISPLAY:
                        begin
                            if (empty)
                            begin
                                load      = 1'b1;
                                ld_status = ST_EMPTY;
                            end
                            else
                            begin
                                rd_en       = 1'b1;
                                rd_addr     = front_reg[AW-1:0];
                                cur_next    = front_reg;
                                single_next = 1'b0;
                                state_next  = S_DOUT;
                            end
                        end
                        default:
                        begin
                            // unused codes are dropped without a beat
                        end
                    endcase
                end
            end
            S_DOUT:
            begin
                if (out_free)
                begin
                    load    = 1'b1;
                    ld_data = rd_data;
                    ld_last = fin;
                    if (fin)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cur_next = cur_reg + IDXW'(1);
                        rd_en    = 1'b1;
                        rd_addr  = cur_next[AW-1:0];
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            front_reg   <= '0;
            end_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            front_reg   <= front_next;
            end_reg     <= end_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        single_reg <= single_next;
        if (load)
        begin
            m_data_reg   <= ld_data;
            m_status_reg <= ld_status;
            m_last_reg   <= ld_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ===== tb/linear_array_deque_tb.sv =====
// Self-checking testbench for the linear array deque: directed corners, then random traffic.
`timescale 1ns / 100ps

module linear_array_deque_tb;
    import lad_pkg::*;

    localparam int DEPTH      = DEPTH_DEF;
    localparam int IDLE_LIMIT = 3000;
    localparam int RAND_ITEMS = 125;
    localparam int DRAIN_WAIT = 20;

    typedef struct {
        logic [ST_W-1:0]   status;
        logic [DATA_W-1:0] data;
        logic              last;
    } beat_t;

    // Tracks the deque contents and indices, queues the beats each operation should produce.
    class deque_tracker;
        logic [DATA_W-1:0] slots [DEPTH];
        int unsigned       front_idx;
        int unsigned       end_idx;
        beat_t             pending_beats [$];
        int                errors;

        function new();
            front_idx = 0;
            end_idx   = 0;
            errors    = 0;
        endfunction

        function void add_beat(logic [ST_W-1:0] st, logic [DATA_W-1:0] dat, logic lst);
            beat_t b;
            b.status = st;
            b.data   = dat;
            b.last   = lst;
            pending_beats.push_back(b);
        endfunction

        function void note_op(logic [OP_W-1:0] op, logic [DATA_W-1:0] val);
            bit is_empty;
            is_empty = (front_idx >= end_idx);
            case (op)
                OP_PUSH_REAR:
                begin
                    if (end_idx >= DEPTH)
                    begin
                        add_beat(ST_FULL, '0, 1'b1);
                    end
                    else
                    begin
                        slots[end_idx] = val;
                        end_idx++;
                        add_beat(ST_OK, '0, 1'b1);
                    end
                end
                OP_PUSH_FRONT:
                begin
                    if (front_idx == 0)
                    begin
                        add_beat(ST_BLOCKED, '0, 1'b1);
                    end
                    else
                    begin
                        front_idx--;
                        slots[front_idx] = val;
                        add_beat(ST_OK, '0, 1'b1);
                    end
                end
                OP_POP_REAR:
                begin
                    if (is_empty)
                    begin
                        add_beat(ST_EMPTY, '0, 1'b1);
                    end
                    else
                    begin
                        end_idx--;
                        add_beat(ST_OK, slots[end_idx], 1'b1);
                    end
                end
                OP_POP_FRONT:
                begin
                    if (is_empty)
                    begin
                        add_beat(ST_EMPTY, '0, 1'b1);
                    end
                    else
                    begin
                        add_beat(ST_OK, slots[front_idx], 1'b1);
                        front_idx++;
                    end
                end
                OP_DISPLAY:
                begin
                    if (is_empty)
                    begin
                        add_beat(ST_EMPTY, '0, 1'b1);
                    end
                    else
                    begin
                        for (int unsigned i = front_idx; i < end_idx; i++)
                            add_beat(ST_OK, slots[i], (i + 1 == end_idx));
                    end
                end
                default: ;  // unused codes: no beat, no state change
            endcase
        endfunction

        function void check_beat(logic [ST_W-1:0] st, logic [DATA_W-1:0] dat, logic lst);
            beat_t e;
            if (pending_beats.size() == 0)
            begin
                $error("unexpected beat: status %0d data %h last %0b", st, dat, lst);
                errors++;
                return;
            end
            e = pending_beats.pop_front();
            if (st !== e.status)
            begin
                $error("status: expected %0d, actual %0d", e.status, st);
                errors++;
            end
            if (dat !== e.data)
            begin
                $error("data: expected %h, actual %h", e.data, dat);
                errors++;
            end
            if (lst !== e.last)
            begin
                $error("last: expected %0b, actual %0b", e.last, lst);
                errors++;
            end
        endfunction

        function int pending();
            return pending_beats.size();
        endfunction
    endclass

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata  = '0;
    logic [OP_W-1:0]   s_tuser  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;
    logic [ST_W-1:0]   m_tuser;
    logic              m_tlast;

    deque_tracker sb = new();
    int           beats_seen = 0;

    linear_array_deque #(
        .DEPTH(DEPTH)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [31:0] value
        .s_tuser  (s_tuser),    // [2:0] operation
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [31:0] data
        .m_tuser  (m_tuser),    // [1:0] status
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    // Offer one beat after a gap, hold it until taken. Called at a clock edge.
    task automatic send_op(logic [OP_W-1:0] op, logic [DATA_W-1:0] val, int gap);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= val;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_op(op, val);
    endtask

    // Receiver: checks beats, stalls at random, holds off once for a long stretch.
    initial
    begin : receiver
        int stall_left;
        int hold_left;
        int calm_left;
        bit held_once;
        stall_left = 0;
        hold_left  = 0;
        calm_left  = 0;
        held_once  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                sb.check_beat(m_tuser, m_tdata, m_tlast);
                beats_seen++;
            end
            if (!held_once && beats_seen >= 40)
            begin
                held_once = 1'b1;
                hold_left = 120;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                if (calm_left > 0)
                    calm_left--;
                else if ($urandom_range(0, 49) == 0)
                    calm_left = $urandom_range(20, 60);
                if (calm_left == 0 && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
                if (stall_left > 0)
                begin
                    stall_left--;
                    m_tready <= 1'b0;
                end
                else
                begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    // Watchdog: cycles with no beat moving on either side.
    initial
    begin : watchdog
        int idle;
        idle = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle = 0;
            else
                idle++;
            if (idle >= IDLE_LIMIT)
            begin
                $display("linear_array_deque_tb: errors");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        logic [DATA_W-1:0] corner_vals [4];
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] val;
        int                counted;
        int                idx;
        int                r;
        bit                burst;

        corner_vals[0] = 32'h8000_0000;
        corner_vals[1] = 32'h7fff_ffff;
        corner_vals[2] = 32'h0000_0000;
        corner_vals[3] = 32'hffff_ffff;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue at reset position
        send_op(OP_DISPLAY,    32'h0,         pick_gap());
        send_op(OP_POP_REAR,   32'h0,         pick_gap());
        send_op(OP_POP_FRONT,  32'h0,         pick_gap());
        send_op(OP_PUSH_FRONT, 32'h1234_5678, pick_gap());
        // fill from the rear
        send_op(OP_PUSH_REAR,  32'h8000_0000, pick_gap());
        send_op(OP_PUSH_REAR,  32'h7fff_ffff, pick_gap());
        send_op(OP_PUSH_REAR,  32'h0000_0000, pick_gap());
        send_op(OP_PUSH_REAR,  32'hffff_ffff, pick_gap());
        send_op(OP_PUSH_REAR,  32'h0000_0001, pick_gap());
        send_op(OP_PUSH_REAR,  32'ha5a5_a5a5, pick_gap());
        send_op(OP_PUSH_REAR,  32'h5a5a_5a5a, pick_gap());
        send_op(OP_PUSH_REAR,  32'h0000_0002, pick_gap());
        // full at rear, front still at zero
        send_op(OP_PUSH_REAR,  32'hdead_beef, pick_gap());
        send_op(OP_PUSH_FRONT, 32'hcafe_f00d, pick_gap());
        send_op(OP_DISPLAY,    32'h0,         pick_gap());
        send_op(OP_POP_FRONT,  32'h0,         pick_gap());
        send_op(OP_POP_FRONT,  32'h0,         pick_gap());
        send_op(OP_PUSH_FRONT, 32'hffff_fffe, pick_gap());
        send_op(OP_POP_REAR,   32'h0,         pick_gap());
        // unused codes are dropped
        send_op(OP_W'(5),      32'hffff_ffff, pick_gap());
        send_op(OP_W'(6),      32'h5555_5555, pick_gap());
        send_op(OP_W'(7),      32'haaaa_aaaa, pick_gap());
        send_op(OP_DISPLAY,    32'h0,         pick_gap());

        counted = 0;
        idx     = 0;
        burst   = 1'b0;
        while (counted < RAND_ITEMS)
        begin
            if (idx % 20 == 0)
                burst = ($urandom_range(0, 3) == 0);
            idx++;
            r = $urandom_range(0, 99);
            if (r < 25)
                op = OP_PUSH_REAR;
            else if (r < 45)
                op = OP_PUSH_FRONT;
            else if (r < 60)
                op = OP_POP_REAR;
            else if (r < 80)
                op = OP_POP_FRONT;
            else if (r < 92)
                op = OP_DISPLAY;
            else
                op = OP_W'($urandom_range(5, 7));
            if ($urandom_range(0, 9) == 0)
                val = corner_vals[$urandom_range(0, 3)];
            else
                val = $urandom;
            send_op(op, val, burst ? 0 : pick_gap());
            if (op <= OP_DISPLAY)
                counted++;
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (sb.pending() != 0)
        begin
            $error("%0d expected beats never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("linear_array_deque_tb: clean");
        else
            $display("linear_array_deque_tb: errors");
        $finish;
    end

endmodule
